// ===== rtl/complex_integer_alu_top_macros.svh =====
// assertion macros used by the alu top rtl file
`ifndef COMPLEX_INTEGER_ALU_TOP_MACROS_SVH
`define COMPLEX_INTEGER_ALU_TOP_MACROS_SVH

// implication checked at every clock edge outside reset
`define CIA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition that must never hold outside reset
`define CIA_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

// ===== rtl/cia_pkg.sv =====
// opcodes and result constants of the complex integer alu
package cia_pkg;

  localparam int OP_WIDTH = 4;
  localparam int RES_WIDTH = 33;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_CONJ   = 4'd4,
    OP_NEG    = 4'd5,
    OP_EQ     = 4'd6,
    OP_INC_RE = 4'd7,
    OP_DEC_RE = 4'd8,
    OP_INC_IM = 4'd9,
    OP_DEC_IM = 4'd10
  } op_t;

  localparam logic signed [RES_WIDTH-1:0] RES_MAX = {1'b0, {(RES_WIDTH-1){1'b1}}};
  localparam logic signed [RES_WIDTH-1:0] RES_MIN = {1'b1, {(RES_WIDTH-1){1'b0}}};

endpackage

// ===== rtl/cia_div_stage.sv =====
// one registered restoring division step, one quotient bit
module cia_div_stage #(
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [QW-1:0] divisor,
  input  logic [QW-1:0] rem_in,
  input  logic [QW-1:0] dvd_in,
  input  logic [QW-1:0] q_in,
  output logic [QW-1:0] rem_out,
  output logic [QW-1:0] dvd_out,
  output logic [QW-1:0] q_out
);

  logic [QW:0]   trial;
  logic [QW:0]   diff;
  logic          fit;
  logic [QW-1:0] rem_next;

  always_comb begin
    trial    = {rem_in, dvd_in[QW-1]};
    diff     = trial - {1'b0, divisor};
    fit      = (trial >= {1'b0, divisor});
    rem_next = fit ? diff[QW-1:0] : trial[QW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= rem_next;
      dvd_out <= {dvd_in[QW-2:0], 1'b0};
      q_out   <= {q_in[QW-2:0], fit};
    end
  end

endmodule

// ===== rtl/complex_integer_alu_top.sv =====
// complex integer alu: pipelined multipliers and bit-serial pipelined divider
//
//   channel | signals                                        | role
//   in      | in_valid in_stall opcode a_real a_imag b_real b_imag | request
//   out     | out_valid out_stall result_real result_imag equal_flag status | result
//
// one request accepted per cycle while in_stall is low
// the divider makes one quotient bit per stage, 2 * PART_WIDTH stages
// rst clears all valid bits; payload registers are not reset
// a held output freezes the whole pipeline and raises in_stall in the same cycle
`include "complex_integer_alu_top_macros.svh"

module complex_integer_alu_top #(
  parameter int PART_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [cia_pkg::OP_WIDTH-1:0]         opcode,
  input  logic signed [PART_WIDTH-1:0]         a_real,
  input  logic signed [PART_WIDTH-1:0]         a_imag,
  input  logic signed [PART_WIDTH-1:0]         b_real,
  input  logic signed [PART_WIDTH-1:0]         b_imag,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [cia_pkg::RES_WIDTH-1:0] result_real,
  output logic signed [cia_pkg::RES_WIDTH-1:0] result_imag,
  output logic                                 equal_flag,
  output logic                                 status
);

  import cia_pkg::*;

  localparam int QW  = 2 * PART_WIDTH;
  localparam int WW  = QW + 2;
  localparam int MW  = (WW > RES_WIDTH) ? WW : RES_WIDTH;
  localparam int NST = QW;

  typedef struct packed {
    logic signed [WW-1:0] rr;
    logic signed [WW-1:0] ri;
    logic                 eq;
    logic                 err;
    logic                 is_div;
    logic                 neg_re;
    logic                 neg_im;
  } side_t;

  function automatic logic signed [RES_WIDTH-1:0] sat_res(input logic signed [WW-1:0] x);
    logic signed [MW-1:0] xe;
    logic signed [MW-1:0] hi;
    logic signed [MW-1:0] lo;
    xe = MW'(x);
    hi = MW'(RES_MAX);
    lo = MW'(RES_MIN);
    if (xe > hi) begin
      return RES_MAX;
    end else if (xe < lo) begin
      return RES_MIN;
    end
    return xe[RES_WIDTH-1:0];
  endfunction

  logic en;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // stage 1: products and simple operations
  logic signed [WW-1:0] ar_x, ai_x, br_x, bi_x;
  logic signed [WW-1:0] rr1_next, ri1_next;
  logic                 eq1_next;

  logic                 v1;
  op_t                  op1;
  logic signed [QW-1:0] p_rr, p_ii, p_ri, p_ir, p_bb_r, p_bb_i;
  logic signed [WW-1:0] rr1, ri1;
  logic                 eq1;

  assign ar_x = WW'(a_real);
  assign ai_x = WW'(a_imag);
  assign br_x = WW'(b_real);
  assign bi_x = WW'(b_imag);

  always_comb begin
    rr1_next = '0;
    ri1_next = '0;
    eq1_next = 1'b0;
    case (op_t'(opcode))
      OP_ADD: begin
        rr1_next = ar_x + br_x;
        ri1_next = ai_x + bi_x;
      end
      OP_SUB: begin
        rr1_next = ar_x - br_x;
        ri1_next = ai_x - bi_x;
      end
      OP_CONJ: begin
        rr1_next = ar_x;
        ri1_next = -ai_x;
      end
      OP_NEG: begin
        rr1_next = -ar_x;
        ri1_next = -ai_x;
      end
      OP_EQ: begin
        eq1_next = (a_real == b_real) && (a_imag == b_imag);
      end
      OP_INC_RE: begin
        rr1_next = ar_x + WW'(1);
        ri1_next = ai_x;
      end
      OP_DEC_RE: begin
        rr1_next = ar_x - WW'(1);
        ri1_next = ai_x;
      end
      OP_INC_IM: begin
        rr1_next = ar_x;
        ri1_next = ai_x + WW'(1);
      end
      OP_DEC_IM: begin
        rr1_next = ar_x;
        ri1_next = ai_x - WW'(1);
      end
      default: begin
        rr1_next = '0;
        ri1_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1    <= op_t'(opcode);
      p_rr   <= QW'(a_real) * QW'(b_real);
      p_ii   <= QW'(a_imag) * QW'(b_imag);
      p_ri   <= QW'(a_real) * QW'(b_imag);
      p_ir   <= QW'(a_imag) * QW'(b_real);
      p_bb_r <= QW'(b_real) * QW'(b_real);
      p_bb_i <= QW'(b_imag) * QW'(b_imag);
      rr1    <= rr1_next;
      ri1    <= ri1_next;
      eq1    <= eq1_next;
    end
  end

  // stage 2: sums, numerator magnitudes, divisor
  logic signed [WW-1:0] mul_re, mul_im, num_re, num_im, num_re_n, num_im_n;
  logic [QW-1:0]        mag_next, nabs_re, nabs_im;
  side_t                side2_next;

  always_comb begin
    mul_re   = WW'(p_rr) - WW'(p_ii);
    mul_im   = WW'(p_ri) + WW'(p_ir);
    num_re   = WW'(p_rr) + WW'(p_ii);
    num_im   = WW'(p_ir) - WW'(p_ri);
    num_re_n = -num_re;
    num_im_n = -num_im;
    nabs_re  = num_re[WW-1] ? num_re_n[QW-1:0] : num_re[QW-1:0];
    nabs_im  = num_im[WW-1] ? num_im_n[QW-1:0] : num_im[QW-1:0];
    mag_next = $unsigned(p_bb_r) + $unsigned(p_bb_i);

    side2_next        = '0;
    side2_next.rr     = rr1;
    side2_next.ri     = ri1;
    side2_next.eq     = eq1;
    if (op1 == OP_MUL) begin
      side2_next.rr = mul_re;
      side2_next.ri = mul_im;
    end else if (op1 == OP_DIV) begin
      if (mag_next == '0) begin
        side2_next.err = 1'b1;
      end else begin
        side2_next.is_div = 1'b1;
        side2_next.neg_re = num_re[WW-1];
        side2_next.neg_im = num_im[WW-1];
      end
    end
  end

  // divider pipeline, index 0 is the stage 2 register
  logic          v_p    [0:NST];
  side_t         side_p [0:NST];
  logic [QW-1:0] mag_p  [0:NST];
  logic [QW-1:0] dvd_re0;
  logic [QW-1:0] dvd_im0;
  wire  [QW-1:0] rem_re [0:NST];
  wire  [QW-1:0] dvd_re [0:NST];
  wire  [QW-1:0] q_re   [0:NST];
  wire  [QW-1:0] rem_im [0:NST];
  wire  [QW-1:0] dvd_im [0:NST];
  wire  [QW-1:0] q_im   [0:NST];

  assign rem_re[0] = '0;
  assign dvd_re[0] = dvd_re0;
  assign q_re[0]   = '0;
  assign rem_im[0] = '0;
  assign dvd_im[0] = dvd_im0;
  assign q_im[0]   = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_p[0] <= 1'b0;
    end else if (en) begin
      v_p[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_p[0] <= side2_next;
      mag_p[0]  <= mag_next;
      dvd_re0   <= nabs_re;
      dvd_im0   <= nabs_im;
    end
  end

  for (genvar k = 0; k < NST; k++) begin : g_div
    cia_div_stage #(.QW(QW)) u_re (
      .clk     (clk),
      .en      (en),
      .divisor (mag_p[k]),
      .rem_in  (rem_re[k]),
      .dvd_in  (dvd_re[k]),
      .q_in    (q_re[k]),
      .rem_out (rem_re[k+1]),
      .dvd_out (dvd_re[k+1]),
      .q_out   (q_re[k+1])
    );

    cia_div_stage #(.QW(QW)) u_im (
      .clk     (clk),
      .en      (en),
      .divisor (mag_p[k]),
      .rem_in  (rem_im[k]),
      .dvd_in  (dvd_im[k]),
      .q_in    (q_im[k]),
      .rem_out (rem_im[k+1]),
      .dvd_out (dvd_im[k+1]),
      .q_out   (q_im[k+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        v_p[k+1] <= 1'b0;
      end else if (en) begin
        v_p[k+1] <= v_p[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_p[k+1] <= side_p[k];
        mag_p[k+1]  <= mag_p[k];
      end
    end
  end

  // output stage: quotient sign, select, saturate
  side_t                sd;
  logic signed [WW-1:0] qv_re, qv_im, fin_re, fin_im;

  always_comb begin
    sd     = side_p[NST];
    qv_re  = signed'({2'b00, q_re[NST]});
    qv_im  = signed'({2'b00, q_im[NST]});
    fin_re = sd.rr;
    fin_im = sd.ri;
    if (sd.is_div) begin
      fin_re = sd.neg_re ? -qv_re : qv_re;
      fin_im = sd.neg_im ? -qv_im : qv_im;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_p[NST];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_real <= sat_res(fin_re);
      result_imag <= sat_res(fin_im);
      equal_flag  <= sd.eq;
      status      <= sd.err;
    end
  end

  `CIA_ASSERT_IMPL(a_err_zero, out_valid && status, result_real == '0 && result_imag == '0, "error result not zero")
  `CIA_ASSERT_IMPL(a_eq_zero, out_valid && equal_flag, result_real == '0 && result_imag == '0 && !status, "equality result not clean")
  `CIA_ASSERT_IMPL(a_rem_low, v_p[NST] && side_p[NST].is_div, rem_re[NST] < mag_p[NST] && rem_im[NST] < mag_p[NST], "divider remainder not below divisor")
  `CIA_ASSERT_IMPL(a_stall_src, in_stall, out_valid && out_stall, "pipeline stalled without held result")

endmodule

// ===== bench/cia_checker.sv =====
// checker that predicts each alu result and compares it with the block output
`timescale 1ns / 100ps

module cia_checker #(
  parameter int PART_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [cia_pkg::OP_WIDTH-1:0]         opcode,
  input  logic signed [PART_WIDTH-1:0]         a_real,
  input  logic signed [PART_WIDTH-1:0]         a_imag,
  input  logic signed [PART_WIDTH-1:0]         b_real,
  input  logic signed [PART_WIDTH-1:0]         b_imag,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [cia_pkg::RES_WIDTH-1:0] result_real,
  input  logic signed [cia_pkg::RES_WIDTH-1:0] result_imag,
  input  logic                                 equal_flag,
  input  logic                                 status,
  output int                                   fail_count,
  output int                                   pending
);
  import cia_pkg::*;

  typedef struct packed {
    logic signed [RES_WIDTH-1:0] re;
    logic signed [RES_WIDTH-1:0] im;
    logic                        eq;
    logic                        st;
  } alu_result_t;

  alu_result_t expected_results[$];

  function automatic logic signed [RES_WIDTH-1:0] clamp_part(longint x);
    longint hi;
    hi = (longint'(1) <<< (RES_WIDTH - 1)) - 1;
    if (x > hi) x = hi;
    if (x < -hi - 1) x = -hi - 1;
    return x[RES_WIDTH-1:0];
  endfunction

  function automatic alu_result_t compute_alu(logic [OP_WIDTH-1:0] op, longint ar, longint ai,
                                              longint br, longint bi);
    alu_result_t r;
    longint rr, ri, mag;
    rr = 0;
    ri = 0;
    r = '0;
    case (op)
      OP_ADD: begin rr = ar + br; ri = ai + bi; end
      OP_SUB: begin rr = ar - br; ri = ai - bi; end
      OP_MUL: begin rr = ar * br - ai * bi; ri = ar * bi + ai * br; end
      OP_DIV: begin
        mag = br * br + bi * bi;
        if (mag == 0) begin
          r.st = 1'b1;
        end else begin
          rr = (ar * br + ai * bi) / mag;
          ri = (ai * br - ar * bi) / mag;
        end
      end
      OP_CONJ: begin rr = ar; ri = -ai; end
      OP_NEG: begin rr = -ar; ri = -ai; end
      OP_EQ: r.eq = (ar == br) && (ai == bi);
      OP_INC_RE: begin rr = ar + 1; ri = ai; end
      OP_DEC_RE: begin rr = ar - 1; ri = ai; end
      OP_INC_IM: begin rr = ar; ri = ai + 1; end
      OP_DEC_IM: begin rr = ar; ri = ai - 1; end
      default: ;
    endcase
    r.re = clamp_part(rr);
    r.im = clamp_part(ri);
    return r;
  endfunction

  always @(posedge clk) begin
    alu_result_t e;
    int errs;
    errs = 0;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result re=%0d im=%0d", result_real, result_imag);
          errs = errs + 1;
        end else begin
          e = expected_results.pop_front();
          if (result_real !== e.re) begin
            $error("result_real expected %0d actual %0d", e.re, result_real);
            errs = errs + 1;
          end
          if (result_imag !== e.im) begin
            $error("result_imag expected %0d actual %0d", e.im, result_imag);
            errs = errs + 1;
          end
          if (equal_flag !== e.eq) begin
            $error("equal_flag expected %0d actual %0d", e.eq, equal_flag);
            errs = errs + 1;
          end
          if (status !== e.st) begin
            $error("status expected %0d actual %0d", e.st, status);
            errs = errs + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(compute_alu(opcode, a_real, a_imag, b_real, b_imag));
      fail_count <= fail_count + errs;
    end
    pending <= expected_results.size();
  end
endmodule

// ===== bench/tb_complex_integer_alu_top.sv =====
// testbench top: request stimulus, receiver stalls and final verdict
`timescale 1ns / 100ps

module tb_complex_integer_alu_top;
  import cia_pkg::*;

  localparam int PW = 16;
  localparam int LATENCY = 2 * PW + 3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int N_RANDOM = 1330;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_WIDTH-1:0] opcode = '0;
  logic signed [PW-1:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [RES_WIDTH-1:0] result_real, result_imag;
  logic equal_flag, status;
  int fail_count, pending;
  int idle_cycles;
  bit hold_long = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  complex_integer_alu_top #(.PART_WIDTH(PW)) u_top (.*);

  cia_checker #(.PART_WIDTH(PW)) u_checker (.*);

  function automatic logic signed [PW-1:0] pick_part();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(PW-1){1'b1}}};
      1: return {1'b1, {(PW-1){1'b0}}};
      2: return '0;
      3: return PW'($signed($urandom_range(0, 6)) - 3);
      default: return PW'($urandom);
    endcase
  endfunction

  task automatic send_request(logic [OP_WIDTH-1:0] op, logic signed [PW-1:0] ar,
                              logic signed [PW-1:0] ai, logic signed [PW-1:0] br,
                              logic signed [PW-1:0] bi);
    in_valid <= 1'b1;
    opcode <= op;
    a_real <= ar;
    a_imag <= ai;
    b_real <= br;
    b_imag <= bi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (hold_long)
      out_stall <= 1'b1;
    else if ($urandom_range(0, 99) < 60)
      out_stall <= 1'b0;
    else
      out_stall <= $urandom_range(0, 2) == 0;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic signed [PW-1:0] mx, mn, x, y;
    int burst;
    mx = {1'b0, {(PW-1){1'b1}}};
    mn = {1'b1, {(PW-1){1'b0}}};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int op = 0; op < 16; op++)
      send_request(op[OP_WIDTH-1:0], mx, mn, mn, mx);
    send_request(OP_DIV, 16'sd7, -16'sd5, '0, '0);
    send_request(OP_DIV, mn, mn, 16'sd1, '0);
    send_request(OP_DIV, -16'sd7, 16'sd3, 16'sd2, '0);
    send_request(OP_MUL, mn, mn, mn, mn);
    send_request(OP_EQ, 16'sd5, -16'sd2, 16'sd5, -16'sd2);
    send_request(OP_INC_RE, mx, mx, '0, '0);
    send_request(OP_DEC_IM, mn, mn, '0, '0);
    fork
      begin
        hold_long = 1'b1;
        repeat (120) @(posedge clk);
        hold_long = 1'b0;
      end
    join_none
    for (int i = 0; i < N_RANDOM; i++) begin
      x = pick_part();
      y = pick_part();
      burst = $urandom_range(0, 9);
      if (burst == 0)
        send_request(OP_WIDTH'($urandom_range(11, 15)), x, y, pick_part(), pick_part());
      else if (burst == 1)
        send_request(OP_EQ, x, y, x, ($urandom_range(0, 1) != 0) ? y : pick_part());
      else
        send_request(OP_WIDTH'($urandom_range(0, 10)), x, y, pick_part(), pick_part());
      if (i > 60) idle_gap();
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cia_pkg.sv
rtl/cia_div_stage.sv
rtl/complex_integer_alu_top.sv
bench/cia_checker.sv
bench/tb_complex_integer_alu_top.sv
